### design/pmqf_pkg.sv
// Shared types, codes and sizes of the priority message queue fan-out unit.
// Depends on nothing; the top level, pmqf_ctrl and pmqf_datapath use it by scoped names.
package pmqf_pkg;

    localparam int QUEUE_DEPTH      = 16;
    localparam int SUBSCRIBER_SLOTS = 16;
    localparam int PRIORITY_LEVELS  = 3;
    localparam int PAYLOAD_BYTES    = 8;

    localparam int PRIO_W    = 2;
    localparam int QIDX_W    = $clog2(QUEUE_DEPTH);
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int SUB_W     = $clog2(SUBSCRIBER_SLOTS);
    localparam int SCNT_W    = $clog2(SUBSCRIBER_SLOTS + 1);
    localparam int PEND_W    = 6;
    localparam int DROP_W    = 32;
    localparam int RAM_DEPTH = PRIORITY_LEVELS * QUEUE_DEPTH;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam int CAP_W     = 5;
    localparam int LIM_W     = 4;
    localparam int IDLIM_W   = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_ID_LIMIT = 2'd2;

    localparam logic [1:0] MODE_POST     = 2'd0;
    localparam logic [1:0] MODE_DISPATCH = 2'd1;
    localparam logic [1:0] MODE_REGISTER = 2'd2;
    localparam logic [1:0] MODE_BAD      = 2'd3;

    localparam logic [3:0] ST_POSTED     = 4'd0;
    localparam logic [3:0] ST_REGISTERED = 4'd1;
    localparam logic [3:0] ST_DELIVERED  = 4'd2;
    localparam logic [3:0] ST_UNHEARD    = 4'd3;
    localparam logic [3:0] ST_EMPTY      = 4'd4;
    localparam logic [3:0] ST_INVALID    = 4'd5;
    localparam logic [3:0] ST_TOO_LONG   = 4'd6;
    localparam logic [3:0] ST_FULL       = 4'd7;
    localparam logic [3:0] ST_TABLE_FULL = 4'd8;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  prio;
        logic [7:0]  source_id;
        logic [7:0]  dest_id;
        logic [7:0]  access_point;
        logic [7:0]  length;
        logic [63:0] payload_word;
    } in_t;

    typedef struct packed {
        logic [3:0]        status;
        logic [3:0]        subscriber;
        logic [7:0]        out_source;
        logic [7:0]        out_dest;
        logic [7:0]        out_access_point;
        logic [3:0]        out_length;
        logic [63:0]       out_payload;
        logic              last;
        logic [PEND_W-1:0] pending_total;
        logic [DROP_W-1:0] queue_drops;
    } out_t;

    typedef struct packed {
        logic [7:0] src;
        logic [7:0] dst;
        logic [7:0] ap;
        logic [3:0] len;
    } hdr_t;

    typedef struct packed {
        hdr_t        hdr;
        logic [63:0] payload;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic capture;
        logic exec_single;
        logic pop;
        logic scan_start;
        logic scan_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_dispatch;
        logic nonempty;
        logic out_free;
        logic scan_empty;
        logic scan_last;
    } stat_t;

endpackage

### design/priority_message_queue_fanout_unit.sv
// Top level of the priority message queue fan-out unit.
// Depends on pmqf_pkg, pmqf_ctrl and pmqf_datapath.
//
// Requests enter on in_valid/in_ready carrying pmqf_pkg::in_t; results leave
// on out_valid/out_ready carrying pmqf_pkg::out_t. Configuration is written
// through cfg_we/cfg_index/cfg_data: 0 queue capacity, 1 payload limit,
// 2 valid id limit, to be taken only while no request is in flight; the user
// must ensure this, as the unit itself does not enforce it.
// A request is captured into the request register while idle and is then
// decided from it. Post, register and an empty dispatch give one result.
// A dispatch reads the message store, then walks the subscriber table
// one slot per cycle while the result register is free, giving at most 16
// results with last set on the final one.
// Reset empties all queues, clears drop counters and the subscriber table
// and restores the configuration defaults; no clearing pass is needed.
// A stalled receiver holds the result register and the walk does not step
// while it is held; no request is taken until all results of the current one
// have been loaded into the result register.
module priority_message_queue_fanout_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pmqf_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pmqf_pkg::out_t                 out_data,
    input  logic                           cfg_we,
    input  logic [pmqf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pmqf_pkg::CFG_W-1:0]     cfg_data
);

    pmqf_pkg::cmd_t  cmd;
    pmqf_pkg::stat_t stat;

    pmqf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pmqf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

### design/pmqf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pmqf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/pmqf_ctrl.sv
// Sequencer of the priority message queue fan-out unit.
// Depends on pmqf_pkg; drives commands to pmqf_datapath and reads its status.
module pmqf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pmqf_pkg::stat_t stat,
    output pmqf_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_dispatch && stat.nonempty)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_WAIT;
                end
                else if (stat.out_free)
                begin
                    cmd.exec_single = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_WAIT:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_empty)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.out_free)
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/pmqf_datapath.sv
// Queues, subscriber table, configuration and result register of the unit.
// Depends on pmqf_pkg and pmqf_ram; driven by commands from pmqf_ctrl.
module pmqf_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pmqf_pkg::in_t                   in_data,
    output pmqf_pkg::out_t                  out_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            cfg_we,
    input  logic [pmqf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmqf_pkg::CFG_W-1:0]      cfg_data,
    input  pmqf_pkg::cmd_t                  cmd,
    output pmqf_pkg::stat_t                 stat
);

    localparam int PL = pmqf_pkg::PRIORITY_LEVELS;
    localparam int SS = pmqf_pkg::SUBSCRIBER_SLOTS;

    logic [pmqf_pkg::CAP_W-1:0]   cap_reg;
    logic [pmqf_pkg::LIM_W-1:0]   lim_reg;
    logic [pmqf_pkg::IDLIM_W-1:0] idlim_reg;

    pmqf_pkg::in_t req_reg;

    logic [pmqf_pkg::QIDX_W-1:0] head_reg [PL];
    logic [pmqf_pkg::QIDX_W-1:0] tail_reg [PL];
    logic [pmqf_pkg::FILL_W-1:0] fill_reg [PL];
    logic [pmqf_pkg::DROP_W-1:0] drop_reg [PL];

    logic [7:0]                  sub_dst_reg [SS];
    logic [7:0]                  sub_ap_reg  [SS];
    logic [pmqf_pkg::SCNT_W-1:0] sub_cnt_reg;

    logic [pmqf_pkg::SUB_W-1:0] scan_idx_reg;
    logic                       pend_valid_reg;
    logic [pmqf_pkg::SUB_W-1:0] pend_idx_reg;

    pmqf_pkg::out_t out_reg;
    pmqf_pkg::out_t out_next;
    logic           out_valid_reg;
    logic           out_load;

    logic                          ram_we;
    logic                          ram_re;
    logic [pmqf_pkg::RAM_AW-1:0]   ram_waddr;
    logic [pmqf_pkg::RAM_AW-1:0]   ram_raddr;
    pmqf_pkg::entry_t              ram_wdata;
    pmqf_pkg::entry_t              ram_rdata;

    logic [pmqf_pkg::FILL_W-1:0] eff_cap;
    logic                        prio_ok;
    logic [pmqf_pkg::PRIO_W-1:0] q_sel;
    logic                        ids_ok;
    logic [pmqf_pkg::LIM_W-1:0]  lim_eff;
    logic                        too_long;
    logic                        full;
    logic [pmqf_pkg::PRIO_W-1:0] disp_q;
    logic                        nonempty;
    logic [pmqf_pkg::PEND_W-1:0] pending_now;
    logic [pmqf_pkg::DROP_W-1:0] drop_sat;
    logic [pmqf_pkg::DROP_W-1:0] drops_now;
    logic [pmqf_pkg::DROP_W-1:0] drops_single;
    logic [3:0]                  st_single;
    logic                        post_ok;
    logic                        drop_inc;
    logic                        reg_ok;
    logic [63:0]                 pay_masked;
    logic                        match;

    function automatic logic [pmqf_pkg::QIDX_W-1:0] next_idx(
        input logic [pmqf_pkg::QIDX_W-1:0] i,
        input logic [pmqf_pkg::FILL_W-1:0] cap
    );
        logic [pmqf_pkg::FILL_W-1:0] n;
        n = pmqf_pkg::FILL_W'(i) + pmqf_pkg::FILL_W'(1);
        return (n >= cap) ? '0 : n[pmqf_pkg::QIDX_W-1:0];
    endfunction

    function automatic logic [pmqf_pkg::RAM_AW-1:0] ram_addr(
        input logic [pmqf_pkg::PRIO_W-1:0] q,
        input logic [pmqf_pkg::QIDX_W-1:0] i
    );
        return pmqf_pkg::RAM_AW'(q) * pmqf_pkg::RAM_AW'(pmqf_pkg::QUEUE_DEPTH)
             + pmqf_pkg::RAM_AW'(i);
    endfunction

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = pmqf_pkg::FILL_W'(1);
        end
        else if (cap_reg > pmqf_pkg::CAP_W'(pmqf_pkg::QUEUE_DEPTH))
        begin
            eff_cap = pmqf_pkg::FILL_W'(pmqf_pkg::QUEUE_DEPTH);
        end
        else
        begin
            eff_cap = pmqf_pkg::FILL_W'(cap_reg);
        end
    end

    assign prio_ok = req_reg.prio < pmqf_pkg::PRIO_W'(PL);
    assign q_sel   = prio_ok ? req_reg.prio : '0;
    assign ids_ok  = ({1'b0, req_reg.dest_id} < idlim_reg)
                  && ({1'b0, req_reg.access_point} < idlim_reg);
    assign lim_eff = (lim_reg > pmqf_pkg::LIM_W'(pmqf_pkg::PAYLOAD_BYTES))
                   ? pmqf_pkg::LIM_W'(pmqf_pkg::PAYLOAD_BYTES) : lim_reg;
    assign too_long = req_reg.length > 8'(lim_eff);
    assign full     = fill_reg[q_sel] >= eff_cap;

    always_comb
    begin
        disp_q      = '0;
        nonempty    = 1'b0;
        pending_now = '0;
        for (int p = PL - 1; p >= 0; p--)
        begin
            if (fill_reg[p] != '0)
            begin
                disp_q   = pmqf_pkg::PRIO_W'(p);
                nonempty = 1'b1;
            end
            pending_now = pending_now + pmqf_pkg::PEND_W'(fill_reg[p]);
        end
    end

    assign drop_sat  = (drop_reg[q_sel] == '1) ? drop_reg[q_sel] : drop_reg[q_sel] + 1'b1;
    assign drops_now = prio_ok ? drop_reg[q_sel] : '1;

    always_comb
    begin
        st_single = pmqf_pkg::ST_INVALID;
        post_ok   = 1'b0;
        drop_inc  = 1'b0;
        reg_ok    = 1'b0;
        priority if (req_reg.mode == pmqf_pkg::MODE_POST)
        begin
            priority if (!prio_ok || !ids_ok)
            begin
                st_single = pmqf_pkg::ST_INVALID;
            end
            else if (too_long)
            begin
                st_single = pmqf_pkg::ST_TOO_LONG;
            end
            else if (full)
            begin
                st_single = pmqf_pkg::ST_FULL;
                drop_inc  = 1'b1;
            end
            else
            begin
                st_single = pmqf_pkg::ST_POSTED;
                post_ok   = 1'b1;
            end
        end
        else if (req_reg.mode == pmqf_pkg::MODE_DISPATCH)
        begin
            st_single = pmqf_pkg::ST_EMPTY;
        end
        else
        begin
            priority if (req_reg.mode == pmqf_pkg::MODE_BAD || !ids_ok)
            begin
                st_single = pmqf_pkg::ST_INVALID;
            end
            else if (sub_cnt_reg >= pmqf_pkg::SCNT_W'(SS))
            begin
                st_single = pmqf_pkg::ST_TABLE_FULL;
            end
            else
            begin
                st_single = pmqf_pkg::ST_REGISTERED;
                reg_ok    = 1'b1;
            end
        end
    end

    assign drops_single = !prio_ok ? '1 : (drop_inc ? drop_sat : drop_reg[q_sel]);

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            pay_masked[8*b +: 8] = (8'(b) < req_reg.length) ? req_reg.payload_word[8*b +: 8]
                                                            : 8'h00;
        end
    end

    assign match = (sub_dst_reg[scan_idx_reg] == ram_rdata.hdr.dst)
                && (sub_ap_reg[scan_idx_reg] == ram_rdata.hdr.ap);

    assign ram_we    = cmd.exec_single && post_ok;
    assign ram_waddr = ram_addr(q_sel, tail_reg[q_sel]);
    assign ram_wdata = '{hdr: '{src: req_reg.source_id, dst: req_reg.dest_id,
                                ap: req_reg.access_point, len: req_reg.length[3:0]},
                         payload: pay_masked};
    assign ram_re    = cmd.pop;
    assign ram_raddr = ram_addr(disp_q, head_reg[disp_q]);

    pmqf_ram #(
        .WIDTH (pmqf_pkg::ENTRY_W),
        .DEPTH (pmqf_pkg::RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_next                  = '0;
        out_next.pending_total    = pending_now;
        out_next.queue_drops      = drops_now;
        out_next.out_source       = ram_rdata.hdr.src;
        out_next.out_dest         = ram_rdata.hdr.dst;
        out_next.out_access_point = ram_rdata.hdr.ap;
        out_next.out_length       = ram_rdata.hdr.len;
        out_next.out_payload      = ram_rdata.payload;
        out_next.status           = pmqf_pkg::ST_DELIVERED;
        out_next.subscriber       = 4'(pend_idx_reg);
        out_next.last             = 1'b1;
        out_load                  = 1'b0;
        priority if (cmd.exec_single)
        begin
            out_load                  = 1'b1;
            out_next.status           = st_single;
            out_next.subscriber       = reg_ok ? 4'(sub_cnt_reg) : 4'd0;
            out_next.out_source       = '0;
            out_next.out_dest         = '0;
            out_next.out_access_point = '0;
            out_next.out_length       = '0;
            out_next.out_payload      = '0;
            out_next.pending_total    = pending_now + pmqf_pkg::PEND_W'(post_ok);
            out_next.queue_drops      = drops_single;
        end
        else if (cmd.scan_step)
        begin
            out_load      = match && pend_valid_reg;
            out_next.last = 1'b0;
        end
        else if (cmd.finish)
        begin
            out_load = 1'b1;
            if (!pend_valid_reg)
            begin
                out_next.status     = pmqf_pkg::ST_UNHEARD;
                out_next.subscriber = 4'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= in_data;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
        if (cmd.exec_single && reg_ok)
        begin
            sub_dst_reg[sub_cnt_reg[pmqf_pkg::SUB_W-1:0]] <= req_reg.dest_id;
            sub_ap_reg[sub_cnt_reg[pmqf_pkg::SUB_W-1:0]]  <= req_reg.access_point;
        end
        if (cmd.scan_step && match)
        begin
            pend_idx_reg <= scan_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= pmqf_pkg::CAP_W'(16);
            lim_reg        <= pmqf_pkg::LIM_W'(8);
            idlim_reg      <= pmqf_pkg::IDLIM_W'(256);
            sub_cnt_reg    <= '0;
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int p = 0; p < PL; p++)
            begin
                head_reg[p] <= '0;
                tail_reg[p] <= '0;
                fill_reg[p] <= '0;
                drop_reg[p] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pmqf_pkg::CFG_QUEUE_CAPACITY: cap_reg   <= cfg_data[pmqf_pkg::CAP_W-1:0];
                    pmqf_pkg::CFG_PAYLOAD_LIMIT:  lim_reg   <= cfg_data[pmqf_pkg::LIM_W-1:0];
                    pmqf_pkg::CFG_VALID_ID_LIMIT: idlim_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.exec_single && post_ok)
            begin
                tail_reg[q_sel] <= next_idx(tail_reg[q_sel], eff_cap);
                fill_reg[q_sel] <= fill_reg[q_sel] + 1'b1;
            end
            if (cmd.exec_single && drop_inc)
            begin
                drop_reg[q_sel] <= drop_sat;
            end
            if (cmd.exec_single && reg_ok)
            begin
                sub_cnt_reg <= sub_cnt_reg + 1'b1;
            end
            if (cmd.pop)
            begin
                head_reg[disp_q] <= next_idx(head_reg[disp_q], eff_cap);
                fill_reg[disp_q] <= fill_reg[disp_q] - 1'b1;
            end
            if (cmd.scan_start)
            begin
                scan_idx_reg   <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg   <= scan_idx_reg + 1'b1;
                pend_valid_reg <= pend_valid_reg || match;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_data         = out_reg;
    assign out_valid        = out_valid_reg;
    assign stat.is_dispatch = req_reg.mode == pmqf_pkg::MODE_DISPATCH;
    assign stat.nonempty    = nonempty;
    assign stat.out_free    = !out_valid_reg || out_ready;
    assign stat.scan_empty  = sub_cnt_reg == '0;
    assign stat.scan_last   = scan_idx_reg
                           == pmqf_pkg::SUB_W'(sub_cnt_reg - pmqf_pkg::SCNT_W'(1));

    a_sub_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sub_cnt_reg <= pmqf_pkg::SCNT_W'(SS))
        else $error("subscriber count beyond table size");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> nonempty)
        else $error("pop from empty queues");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store read and written together");

endmodule

### sim/priority_message_queue_fanout_checker.sv
// Checker of the priority message queue fan-out unit: tracks configuration writes, predicts
// the results of every accepted request and compares them with the result channel.
// Depends on pmqf_pkg.
module priority_message_queue_fanout_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  pmqf_pkg::in_t                  in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  pmqf_pkg::out_t                 out_data,
    input  logic                           cfg_we,
    input  logic [pmqf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pmqf_pkg::CFG_W-1:0]     cfg_data,
    output int                             mismatch_count,
    output int                             awaiting,
    output int                             queued_msgs
);
    timeunit 1ns;
    timeprecision 1ps;

    import pmqf_pkg::*;

    hdr_t        stored_hdr [PRIORITY_LEVELS][QUEUE_DEPTH];
    logic [63:0] stored_pay [PRIORITY_LEVELS][QUEUE_DEPTH];
    int          head_at [PRIORITY_LEVELS];
    int          tail_at [PRIORITY_LEVELS];
    int          fill [PRIORITY_LEVELS];
    logic [31:0] drops [PRIORITY_LEVELS];
    logic [7:0]  sub_dst [SUBSCRIBER_SLOTS];
    logic [7:0]  sub_ap [SUBSCRIBER_SLOTS];
    logic        sub_on [SUBSCRIBER_SLOTS];
    int          sub_cnt;
    logic [4:0]  capacity;
    logic [3:0]  size_limit;
    logic [8:0]  id_limit;
    out_t        due_results[$];

    function automatic int cap_in_use();
        if (capacity < 1)
            return 1;
        if (capacity > QUEUE_DEPTH)
            return QUEUE_DEPTH;
        return int'(capacity);
    endfunction

    function automatic int advance(int i);
        return (i + 1 >= cap_in_use()) ? 0 : i + 1;
    endfunction

    function automatic out_t result_of(logic [3:0] st, int sub, logic with_msg, hdr_t h,
                                       logic [63:0] pay, logic lst, logic [31:0] drp);
        out_t r;
        r.status           = st;
        r.subscriber       = sub[3:0];
        r.out_source       = with_msg ? h.src : 8'd0;
        r.out_dest         = with_msg ? h.dst : 8'd0;
        r.out_access_point = with_msg ? h.ap : 8'd0;
        r.out_length       = with_msg ? h.len : 4'd0;
        r.out_payload      = with_msg ? pay : 64'd0;
        r.last             = lst;
        r.pending_total    = 6'(fill[0] + fill[1] + fill[2]);
        r.queue_drops      = drp;
        return r;
    endfunction

    task automatic predict_request(in_t req);
        logic        prio_ok;
        logic        ids_ok;
        logic [3:0]  st;
        int          q;
        int          n;
        hdr_t        h;
        logic [63:0] pay;
        logic [31:0] drp;
        int          lim;
        prio_ok = req.prio < PRIORITY_LEVELS;
        ids_ok  = (req.dest_id < id_limit) && (req.access_point < id_limit);
        h       = '0;
        pay     = '0;
        if (req.mode == MODE_POST) begin
            if (!prio_ok || !ids_ok) begin
                st = ST_INVALID;
            end
            else begin
                q   = req.prio;
                lim = (size_limit > PAYLOAD_BYTES) ? PAYLOAD_BYTES : size_limit;
                if (req.length > lim) begin
                    st = ST_TOO_LONG;
                end
                else if (fill[q] >= cap_in_use()) begin
                    if (drops[q] != 32'hFFFF_FFFF)
                        drops[q]++;
                    st = ST_FULL;
                end
                else begin
                    h.src = req.source_id;
                    h.dst = req.dest_id;
                    h.ap  = req.access_point;
                    h.len = req.length[3:0];
                    stored_hdr[q][tail_at[q]] = h;
                    stored_pay[q][tail_at[q]] = (req.length >= 8) ? req.payload_word :
                        req.payload_word & ((64'd1 << (8 * req.length)) - 64'd1);
                    tail_at[q] = advance(tail_at[q]);
                    fill[q]++;
                    st = ST_POSTED;
                end
            end
            drp = prio_ok ? drops[req.prio] : 32'hFFFF_FFFF;
            due_results.push_back(result_of(st, 0, 1'b0, h, pay, 1'b1, drp));
        end
        else if (req.mode == MODE_DISPATCH) begin
            drp = prio_ok ? drops[req.prio] : 32'hFFFF_FFFF;
            q = -1;
            for (int p = PRIORITY_LEVELS - 1; p >= 0; p--)
                if (fill[p] > 0)
                    q = p;
            if (q < 0) begin
                due_results.push_back(result_of(ST_EMPTY, 0, 1'b0, h, pay, 1'b1, drp));
            end
            else begin
                h   = stored_hdr[q][head_at[q]];
                pay = stored_pay[q][head_at[q]];
                head_at[q] = advance(head_at[q]);
                fill[q]--;
                n = 0;
                for (int i = 0; i < sub_cnt; i++) begin
                    if (sub_on[i] && sub_dst[i] == h.dst && sub_ap[i] == h.ap) begin
                        due_results.push_back(result_of(ST_DELIVERED, i, 1'b1, h, pay,
                                                        1'b0, drp));
                        n++;
                    end
                end
                if (n == 0)
                    due_results.push_back(result_of(ST_UNHEARD, 0, 1'b1, h, pay, 1'b1, drp));
                else
                    due_results[$].last = 1'b1;
            end
        end
        else begin
            drp = prio_ok ? drops[req.prio] : 32'hFFFF_FFFF;
            if (req.mode == MODE_BAD || !ids_ok) begin
                due_results.push_back(result_of(ST_INVALID, 0, 1'b0, h, pay, 1'b1, drp));
            end
            else if (sub_cnt >= SUBSCRIBER_SLOTS) begin
                due_results.push_back(result_of(ST_TABLE_FULL, 0, 1'b0, h, pay, 1'b1, drp));
            end
            else begin
                sub_dst[sub_cnt] = req.dest_id;
                sub_ap[sub_cnt]  = req.access_point;
                sub_on[sub_cnt]  = 1'b1;
                due_results.push_back(result_of(ST_REGISTERED, sub_cnt, 1'b0, h, pay,
                                                1'b1, drp));
                sub_cnt++;
            end
        end
    endtask

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_t want;
        if (!rst_n) begin
            for (int p = 0; p < PRIORITY_LEVELS; p++) begin
                head_at[p] = 0;
                tail_at[p] = 0;
                fill[p]    = 0;
                drops[p]   = '0;
            end
            for (int i = 0; i < SUBSCRIBER_SLOTS; i++)
                sub_on[i] = 1'b0;
            sub_cnt        = 0;
            capacity       = 5'd16;
            size_limit     = 4'd8;
            id_limit       = 9'd256;
            mismatch_count = 0;
            due_results.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_QUEUE_CAPACITY: capacity   = cfg_data[4:0];
                    CFG_PAYLOAD_LIMIT:  size_limit = cfg_data[3:0];
                    CFG_VALID_ID_LIMIT: id_limit   = cfg_data[8:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_request(in_data);
            if (out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result with no request outstanding: status %0d", out_data.status);
                    mismatch_count++;
                end
                else begin
                    want = due_results.pop_front();
                    compare_field("status", want.status, out_data.status);
                    compare_field("subscriber", want.subscriber, out_data.subscriber);
                    compare_field("out_source", want.out_source, out_data.out_source);
                    compare_field("out_dest", want.out_dest, out_data.out_dest);
                    compare_field("out_access_point", want.out_access_point,
                                  out_data.out_access_point);
                    compare_field("out_length", want.out_length, out_data.out_length);
                    compare_field("out_payload", want.out_payload, out_data.out_payload);
                    compare_field("last", want.last, out_data.last);
                    compare_field("pending_total", want.pending_total, out_data.pending_total);
                    compare_field("queue_drops", want.queue_drops, out_data.queue_drops);
                end
            end
        end
        awaiting    = due_results.size();
        queued_msgs = fill[0] + fill[1] + fill[2];
    end

endmodule

### sim/priority_message_queue_fanout_unit_test.sv
// Testbench top of the priority message queue fan-out unit: drives requests, result
// stalls and configuration phases, and gives the verdict.
// Depends on pmqf_pkg, priority_message_queue_fanout_unit and its checker.
module priority_message_queue_fanout_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pmqf_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_t                  in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_t                 out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_QUEUE_CAPACITY;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   mismatch_count;
    int                   awaiting;
    int                   queued_msgs;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   quiet_cycles = 0;

    priority_message_queue_fanout_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    priority_message_queue_fanout_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .awaiting       (awaiting),
        .queued_msgs    (queued_msgs)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_request(in_t req);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        forever begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
    endtask

    function automatic in_t make_request(logic [1:0] md, logic [1:0] pr, logic [7:0] dst,
                                         logic [7:0] ap, logic [7:0] len, logic [63:0] pay);
        in_t r;
        r.mode         = md;
        r.prio         = pr;
        r.source_id    = 8'($urandom);
        r.dest_id      = dst;
        r.access_point = ap;
        r.length       = len;
        r.payload_word = pay;
        return r;
    endfunction

    function automatic in_t random_request(int lim);
        int          pick;
        logic [1:0]  md;
        logic [7:0]  dst;
        logic [7:0]  ap;
        logic [7:0]  len;
        pick = $urandom_range(99);
        md   = (pick < 50) ? MODE_POST : (pick < 88) ? MODE_DISPATCH :
               (pick < 97) ? MODE_REGISTER : MODE_BAD;
        dst  = ($urandom_range(9) < 8) ? 8'($urandom_range(1)) : 8'($urandom);
        ap   = ($urandom_range(9) < 8) ? 8'($urandom_range(1)) : 8'($urandom);
        len  = ($urandom_range(9) < 8) ? 8'($urandom_range(lim)) : 8'($urandom);
        return make_request(md, ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2)),
                            dst, ap, len, {$urandom, $urandom});
    endfunction

    task automatic wait_idle();
        forever begin
            @(negedge clk);
            if (awaiting == 0)
                break;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge clk);
    endtask

    initial begin
        int caps [6]   = '{16, 1, 0, 4, 31, 9};
        int limits [6] = '{8, 0, 15, 3, 8, 5};
        int ids [6]    = '{256, 0, 511, 100, 255, 200};
        int sends [4]  = '{0, 64, 0, 10};
        int stalls [4] = '{0, 0, 64, 10};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_request(MODE_DISPATCH, 2'd0, 8'd0, 8'd0, 8'd0, '0));
        send_request(make_request(MODE_BAD, 2'd1, 8'd0, 8'd0, 8'd0, '0));
        send_request(make_request(MODE_POST, 2'd3, 8'd0, 8'd0, 8'd0, '0));
        send_request(make_request(MODE_REGISTER, 2'd3, 8'd0, 8'd0, 8'd0, '0));
        send_request(make_request(MODE_REGISTER, 2'd0, 8'd0, 8'd0, 8'd0, '0));
        send_request(make_request(MODE_REGISTER, 2'd0, 8'd255, 8'd255, 8'd0, '0));
        send_request(make_request(MODE_POST, 2'd2, 8'd0, 8'd0, 8'd0, '1));
        send_request(make_request(MODE_POST, 2'd1, 8'd255, 8'd255, 8'd8, '1));
        send_request(make_request(MODE_POST, 2'd0, 8'd5, 8'd5, 8'd3, 64'h0123_4567_89AB_CDEF));
        send_request(make_request(MODE_POST, 2'd0, 8'd0, 8'd0, 8'd9, '1));
        send_request(make_request(MODE_POST, 2'd1, 8'd0, 8'd0, 8'd255, '1));
        send_request(make_request(MODE_DISPATCH, 2'd3, 8'd0, 8'd0, 8'd0, '0));
        send_request(make_request(MODE_DISPATCH, 2'd0, 8'd0, 8'd0, 8'd0, '0));
        send_request(make_request(MODE_DISPATCH, 2'd2, 8'd0, 8'd0, 8'd0, '0));
        send_request(make_request(MODE_DISPATCH, 2'd1, 8'd0, 8'd0, 8'd0, '0));
        in_valid <= 1'b0;

        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            forever begin
                wait_idle();
                if (queued_msgs == 0)
                    break;
                send_request(make_request(MODE_DISPATCH, 2'd0, 8'd0, 8'd0, 8'd0, '0));
                in_valid <= 1'b0;
            end
            write_register(CFG_QUEUE_CAPACITY, caps[ph]);
            write_register(CFG_PAYLOAD_LIMIT, limits[ph]);
            write_register(CFG_VALID_ID_LIMIT, ids[ph]);
            cfg_we <= 1'b0;
            send_idle_pct  = sends[ph % 4];
            recv_stall_pct = stalls[ph % 4];
            repeat (40)
                send_request(random_request((limits[ph] > 8) ? 8 : limits[ph]));
            in_valid <= 1'b0;
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && awaiting == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
design/pmqf_pkg.sv
design/pmqf_ram.sv
design/pmqf_ctrl.sv
design/pmqf_datapath.sv
design/priority_message_queue_fanout_unit.sv
sim/priority_message_queue_fanout_checker.sv
sim/priority_message_queue_fanout_unit_test.sv
